// ===== rtl/prd_pkg.sv =====
// Package for the pinhole ray direction unit.
// Holds field widths, register indexes, payload structs and inter-cell structs.
// No dependencies.
package prd_pkg;

	localparam int COMP_WIDTH = 16;
	localparam int FRAC_BITS  = 14;
	localparam int CAM_FRAC   = 12;
	localparam int CAM_WIDTH  = 16;
	localparam int REG_WIDTH  = 48;
	localparam int CAM_ALIGN  = FRAC_BITS - CAM_FRAC;
	localparam int PROD_W     = 33;
	localparam int MAG_W      = 37;
	localparam int LEN_W      = 6;
	localparam int NORM_W     = 31;
	localparam int SQ_W       = 64;
	localparam int ROOT_STEPS = 32;
	localparam int QUO_W      = 16;
	localparam int DIV_W      = 50;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_X_AXIS = 2'd0;
	localparam cfg_idx_t CFG_Y_AXIS = 2'd1;
	localparam cfg_idx_t CFG_NORMAL = 2'd2;
	localparam cfg_idx_t CFG_CAM    = 2'd3;

	typedef struct packed {
		logic signed [COMP_WIDTH-1:0] coord_x;
		logic signed [COMP_WIDTH-1:0] coord_y;
	} in_t;

	typedef struct packed {
		logic signed [COMP_WIDTH-1:0] dir_x;
		logic signed [COMP_WIDTH-1:0] dir_y;
		logic signed [COMP_WIDTH-1:0] dir_z;
		logic                         degenerate;
	} out_t;

	// data that rides alongside the root and divide cells
	typedef struct packed {
		logic [2:0][NORM_W-1:0] m;
		logic [2:0]             neg;
		logic                   degen;
	} side_t;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] root;
		side_t           side;
	} sqrt_t;

	typedef struct packed {
		logic [2:0][DIV_W-1:0] rem;
		logic [DIV_W-1:0]      dvsr;
		logic [2:0][QUO_W-1:0] quo;
		side_t                 side;
	} div_t;

endpackage

// ===== rtl/pinhole_ray_direction_unit.sv =====
// Top level of the pinhole ray direction unit: configuration registers, front
// pipeline, square root cell chain, divide cell chain and output register.
// Depends on prd_pkg, prd_front, prd_sqrt_cell, prd_div_cell.
//
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | in_data (coord_x, coord_y)
//  out     | output    | out_valid/out_stall | out_data (dir_x/y/z, degenerate)
//  cfg     | input     | cfg_we            | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; the pipeline holds 7 front
// stages, 32 root cells, one dividend stage, 16 divide cells and the output register.
// The whole pipeline advances together; it holds while the output register is
// full and stalled, and in_stall follows from that.
// Reset clears valid bits and loads the register reset values.
module pinhole_ray_direction_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  prd_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output prd_pkg::out_t                 out_data,
	input  logic                          cfg_we,
	input  prd_pkg::cfg_idx_t             cfg_index,
	input  logic [prd_pkg::REG_WIDTH-1:0] cfg_data
);
	import prd_pkg::*;

	logic [REG_WIDTH-1:0] x_axis_q, y_axis_q, normal_q;
	logic [CAM_WIDTH-1:0] cam_q;
	logic                 adv;
	logic                 out_valid_q;
	out_t                 out_q;

	logic [ROOT_STEPS:0] sq_vld;
	sqrt_t               sq_d [ROOT_STEPS+1];
	logic [QUO_W:0]      dv_vld;
	div_t                dv_d [QUO_W+1];
	logic                prep_vld_s1;

	out_t                 res;
	logic [QUO_W-1:0]     qsat;

	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_axis_q <= 48'h0000_0000_4000;
			y_axis_q <= 48'h0000_4000_0000;
			normal_q <= 48'h4000_0000_0000;
			cam_q    <= 16'h1000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_X_AXIS: x_axis_q <= cfg_data;
				CFG_Y_AXIS: y_axis_q <= cfg_data;
				CFG_NORMAL: normal_q <= cfg_data;
				CFG_CAM:    cam_q    <= cfg_data[CAM_WIDTH-1:0];
				default:    cam_q    <= cam_q;
			endcase
		end
	end

	prd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (in_valid),
		.in_data  (in_data),
		.x_axis   (x_axis_q),
		.y_axis   (y_axis_q),
		.normal   (normal_q),
		.cam      (cam_q),
		.vld_o    (sq_vld[0]),
		.d_o      (sq_d[0])
	);

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_sqrt
		prd_sqrt_cell #(.STEP(k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_i  (sq_vld[k]),
			.d_i    (sq_d[k]),
			.vld_o  (sq_vld[k+1]),
			.d_o    (sq_d[k+1])
		);
	end

	// dividend m*2^(FRAC_BITS+1) + len over divisor 2*len gives the rounded quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_vld_s1 <= 1'b0;
		end else if (adv) begin
			prep_vld_s1 <= sq_vld[ROOT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dv_d[0].rem[i] <= (DIV_W'(sq_d[ROOT_STEPS].side.m[i]) << (FRAC_BITS + 1))
					+ DIV_W'(sq_d[ROOT_STEPS].root);
			end
			dv_d[0].dvsr <= DIV_W'(sq_d[ROOT_STEPS].root) << 1;
			dv_d[0].quo  <= '0;
			dv_d[0].side <= sq_d[ROOT_STEPS].side;
		end
	end

	assign dv_vld[0] = prep_vld_s1;

	for (genvar c = 0; c < QUO_W; c++) begin : g_div
		prd_div_cell #(.SHIFT(QUO_W - 1 - c)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_i  (dv_vld[c]),
			.d_i    (dv_d[c]),
			.vld_o  (dv_vld[c+1]),
			.d_o    (dv_d[c+1])
		);
	end

	always_comb begin
		res.dir_x      = '0;
		res.dir_y      = '0;
		res.dir_z      = '0;
		res.degenerate = dv_d[QUO_W].side.degen;
		for (int i = 0; i < 3; i++) begin
			// clamp to the signed range, then apply the sign
			qsat = dv_d[QUO_W].quo[i][QUO_W-1] ? {1'b0, {(QUO_W-1){1'b1}}}
				: dv_d[QUO_W].quo[i];
			if (!dv_d[QUO_W].side.degen) begin
				case (i)
					0:       res.dir_x = dv_d[QUO_W].side.neg[i] ? -qsat : qsat;
					1:       res.dir_y = dv_d[QUO_W].side.neg[i] ? -qsat : qsat;
					default: res.dir_z = dv_d[QUO_W].side.neg[i] ? -qsat : qsat;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_vld[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

endmodule

// ===== rtl/prd_front.sv =====
// Front pipeline of the pinhole ray direction unit: products, sum, magnitude,
// normalisation and sum of squares. Depends on prd_pkg.
module prd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  prd_pkg::in_t                  in_data,
	input  logic [prd_pkg::REG_WIDTH-1:0] x_axis,
	input  logic [prd_pkg::REG_WIDTH-1:0] y_axis,
	input  logic [prd_pkg::REG_WIDTH-1:0] normal,
	input  logic [prd_pkg::CAM_WIDTH-1:0] cam,
	output logic                          vld_o,
	output prd_pkg::sqrt_t                d_o
);
	import prd_pkg::*;

	logic signed [2:0][2*COMP_WIDTH-1:0] px_s1, py_s1;
	logic signed [2:0][PROD_W-1:0]       pn_s1;
	logic signed [2:0][MAG_W-1:0]        sum_s2;
	logic [2:0][MAG_W-1:0]               mag_s3, mag_s4;
	logic [2:0]                          neg_s3, neg_s4, neg_s5, neg_s6;
	logic [LEN_W-1:0]                    len_s4;
	logic [2:0][NORM_W-1:0]              m_s5, m_s6;
	logic                                dg_s5, dg_s6;
	logic [2:0][2*NORM_W-1:0]            sq_s6;
	logic [6:1]                          v_q;

	logic signed [2:0][2*COMP_WIDTH-1:0] px, py;
	logic signed [2:0][PROD_W-1:0]       pn;
	logic [MAG_W-1:0]                    mag_or;
	logic [LEN_W-1:0]                    maxlen;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			px[i] = in_data.coord_x
				* $signed(x_axis[i*COMP_WIDTH +: COMP_WIDTH]);
			py[i] = in_data.coord_y
				* $signed(y_axis[i*COMP_WIDTH +: COMP_WIDTH]);
			pn[i] = $signed({1'b0, cam}) * $signed(normal[i*COMP_WIDTH +: COMP_WIDTH]);
		end
	end

	always_comb begin
		mag_or = mag_s3[0] | mag_s3[1] | mag_s3[2];
		maxlen = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (mag_or[i]) begin
				maxlen = LEN_W'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[5:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= px;
			py_s1 <= py;
			pn_s1 <= pn;
			for (int i = 0; i < 3; i++) begin
				sum_s2[i] <= MAG_W'($signed(px_s1[i])) + MAG_W'($signed(py_s1[i]))
					+ (MAG_W'($signed(pn_s1[i])) <<< CAM_ALIGN);
				neg_s3[i] <= sum_s2[i][MAG_W-1];
				mag_s3[i] <= sum_s2[i][MAG_W-1] ? MAG_W'(-sum_s2[i]) : MAG_W'(sum_s2[i]);
			end
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			len_s4 <= maxlen;
			// scale so the largest magnitude lands in [2^30, 2^31)
			for (int i = 0; i < 3; i++) begin
				m_s5[i] <= NORM_W'({mag_s4[i], {NORM_W{1'b0}}} >> len_s4);
			end
			neg_s5 <= neg_s4;
			dg_s5  <= (len_s4 == '0);
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= m_s5[i] * m_s5[i];
			end
			m_s6   <= m_s5;
			neg_s6 <= neg_s5;
			dg_s6  <= dg_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= v_q[6];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o.rem        <= SQ_W'(sq_s6[0]) + SQ_W'(sq_s6[1]) + SQ_W'(sq_s6[2]);
			d_o.root       <= '0;
			d_o.side.m     <= m_s6;
			d_o.side.neg   <= neg_s6;
			d_o.side.degen <= dg_s6;
		end
	end

endmodule

// ===== rtl/prd_sqrt_cell.sv =====
// One cell of the integer square root chain: settles one root bit per cell.
// Depends on prd_pkg.
module prd_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  prd_pkg::sqrt_t d_i,
	output logic           vld_o,
	output prd_pkg::sqrt_t d_o
);
	import prd_pkg::*;

	localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (62 - 2*STEP);

	logic [SQ_W-1:0] trial;
	sqrt_t           nxt;

	always_comb begin
		trial = d_i.root + BITV;
		nxt   = d_i;
		if (d_i.rem >= trial) begin
			nxt.rem  = d_i.rem - trial;
			nxt.root = (d_i.root >> 1) + BITV;
		end else begin
			nxt.root = d_i.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o <= nxt;
		end
	end

endmodule

// ===== rtl/prd_div_cell.sv =====
// One cell of the restoring divide chain: one quotient bit for all three lanes.
// Depends on prd_pkg.
module prd_div_cell #(
	parameter int SHIFT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  prd_pkg::div_t d_i,
	output logic          vld_o,
	output prd_pkg::div_t d_o
);
	import prd_pkg::*;

	logic [DIV_W-1:0] sub;
	div_t             nxt;

	always_comb begin
		sub = d_i.dvsr << SHIFT;
		nxt = d_i;
		for (int i = 0; i < 3; i++) begin
			if (d_i.rem[i] >= sub) begin
				nxt.rem[i]        = d_i.rem[i] - sub;
				nxt.quo[i][SHIFT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o <= nxt;
		end
	end

endmodule
